/* design/assert_macros.svh */
// Assertion macros shared by the receiver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define SRR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

`define SRR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`else

`define SRR_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define SRR_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* design/srr_pkg.sv */
// Types and constants shared by the selective repeat receiver modules.
`timescale 1ns / 1ps
`default_nettype none

package srr_pkg;

    localparam int unsigned SEQ_BITS = 32;
    localparam int unsigned TAG_BITS = 10;
    localparam int unsigned LEN_BITS = 11;
    localparam int unsigned CFG_BITS = 6;
    localparam logic [CFG_BITS-1:0] WINDOW_RESET = 6'd8;

    typedef enum logic [1:0] {
        PKT_START = 2'd0,
        PKT_END   = 2'd1,
        PKT_DATA  = 2'd2,
        PKT_ACK   = 2'd3
    } t_pkt_type;

    typedef enum logic [1:0] {
        KIND_DELIVER = 2'd0,
        KIND_ACK     = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic [LEN_BITS-1:0] len;
    } t_slot;

    typedef struct packed {
        t_kind               kind;
        logic [SEQ_BITS-1:0] ack_seq;
        logic [TAG_BITS-1:0] tag;
        logic [LEN_BITS-1:0] len;
        logic                last;
    } t_result;

endpackage

`default_nettype wire

/* design/srr_slot_mem.sv */
// Reorder store holding the payload handle and length of each buffered packet.
`timescale 1ns / 1ps
`default_nettype none

module srr_slot_mem #(
    parameter int unsigned DEPTH = 32,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic           i_clk,
    input  wire logic           i_wr_en,
    input  wire logic [AW-1:0]  i_wr_addr,
    input  wire srr_pkg::t_slot i_wr_data,
    input  wire logic           i_rd_en,
    input  wire logic [AW-1:0]  i_rd_addr,
    output srr_pkg::t_slot      o_rd_data
);
    import srr_pkg::*;

    t_slot r_mem [DEPTH];
    t_slot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* design/srr_out_reg.sv */
// Output register that holds one result until the downstream side takes it.
`timescale 1ns / 1ps
`default_nettype none

module srr_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire srr_pkg::t_result i_res,
    output logic                  o_ready,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output srr_pkg::t_result      o_res
);
    import srr_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_push) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

/* design/selective_repeat_receiver.sv */
// Top level of the selective repeat receiver with cumulative acknowledgements.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Takes one received packet header per transaction and answers with in-order
// payload deliveries followed by one acknowledgement, one acknowledgement, or
// one protocol error; some headers get no answer. o_last marks the final result
// of each header. Headers are handled one at a time. An in-order DATA packet
// also drains the buffered packets behind it; each drained slot needs a
// registered read of the reorder memory followed by the output push. The window
// register is written through the configuration channel, which is always ready;
// the window in use is its value clamped to 1..WINDOW.
module selective_repeat_receiver #(
    parameter int unsigned WINDOW      = 32,
    parameter int unsigned PAYLOAD_MAX = 1456
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_pkt_type,
    input  wire logic [31:0] i_seq_num,
    input  wire logic        i_crc_ok,
    input  wire logic [9:0]  i_payload_tag,
    input  wire logic [10:0] i_payload_len,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_kind,
    output logic [31:0]      o_ack_seq,
    output logic [9:0]       o_payload_tag_res,
    output logic [10:0]      o_payload_len_res,
    output logic             o_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [5:0]  i_cfg_data
);
    import srr_pkg::*;

    localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned SUM_W = $clog2(3 * WINDOW);
    localparam int unsigned WIN_W = $clog2(WINDOW + 1);
    localparam longint unsigned SEQ_SPAN = 64'd1 << SEQ_BITS;
    localparam int unsigned WRAP_ADJ =
        32'((64'(WINDOW) - (SEQ_SPAN % 64'(WINDOW))) % 64'(WINDOW));

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EVAL = 6'b000010,
        S_EMIT = 6'b000100,
        S_RD   = 6'b001000,
        S_RDW  = 6'b010000,
        S_ACK  = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    t_state                r_after, n_after;
    logic                  r_open, n_open;
    logic [SEQ_BITS-1:0]   r_exp, n_exp;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [WINDOW-1:0]     r_valid, n_valid;
    logic [CFG_BITS-1:0]   r_window_size;
    t_result               r_pend, n_pend;

    logic [1:0]            r_type;
    logic [SEQ_BITS-1:0]   r_seq;
    logic                  r_crc;
    logic [TAG_BITS-1:0]   r_tag;
    logic [LEN_BITS-1:0]   r_len;

    logic                  in_accept;
    logic [LEN_BITS-1:0]   sat_len;
    logic [WIN_W-1:0]      eff_win;
    logic [SEQ_BITS:0]     diff;
    logic [SEQ_BITS-1:0]   off;
    logic                  wrapped;
    logic                  stale;
    logic                  in_win;
    logic [SUM_W-1:0]      sum;
    logic [IDX_W-1:0]      slot_buf;
    logic [IDX_W-1:0]      idx_inc;
    logic                  more;

    logic                  mem_wr_en;
    logic                  mem_rd_en;
    t_slot                 mem_wr_data;
    t_slot                 mem_rd_data;

    logic                  out_push;
    logic                  out_ready;
    t_result               out_res;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign sat_len = (32'(i_payload_len) > PAYLOAD_MAX) ? LEN_BITS'(PAYLOAD_MAX)
                                                         : i_payload_len;

    always_comb begin
        if (r_window_size == '0) begin
            eff_win = WIN_W'(1);
        end else if (32'(r_window_size) > WINDOW) begin
            eff_win = WIN_W'(WINDOW);
        end else begin
            eff_win = WIN_W'(r_window_size);
        end
    end

    assign diff    = {1'b0, r_seq} - {1'b0, r_exp};
    assign off     = diff[SEQ_BITS-1:0];
    assign wrapped = diff[SEQ_BITS];
    assign stale   = off[SEQ_BITS-1];
    assign in_win  = off < 32'(eff_win);

    // A sequence number that wrapped past zero moves its slot by the part of 2^32
    // that is not a whole multiple of the window.
    assign sum     = SUM_W'(r_idx) + off[SUM_W-1:0]
                   + (wrapped ? SUM_W'(WRAP_ADJ) : SUM_W'(0));

    always_comb begin
        if (32'(sum) >= 2 * WINDOW) begin
            slot_buf = IDX_W'(sum - SUM_W'(2 * WINDOW));
        end else if (32'(sum) >= WINDOW) begin
            slot_buf = IDX_W'(sum - SUM_W'(WINDOW));
        end else begin
            slot_buf = IDX_W'(sum);
        end
    end

    always_comb begin
        if (r_exp == '1) begin
            idx_inc = '0;
        end else if (r_idx == IDX_W'(WINDOW - 1)) begin
            idx_inc = '0;
        end else begin
            idx_inc = r_idx + IDX_W'(1);
        end
    end

    assign more = r_valid[idx_inc] && (idx_inc != r_idx);

    assign mem_wr_data.tag = r_tag;
    assign mem_wr_data.len = r_len;

    always_comb begin
        n_state   = r_state;
        n_after   = r_after;
        n_open    = r_open;
        n_exp     = r_exp;
        n_idx     = r_idx;
        n_valid   = r_valid;
        n_pend    = r_pend;
        mem_wr_en = 1'b0;
        mem_rd_en = 1'b0;
        out_push  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state        = S_IDLE;
                n_after        = S_IDLE;
                n_pend.kind    = KIND_ACK;
                n_pend.ack_seq = '0;
                n_pend.tag     = '0;
                n_pend.len     = '0;
                n_pend.last    = 1'b1;
                if (!r_open) begin
                    if (r_type == PKT_START) begin
                        n_open         = 1'b1;
                        n_exp          = '0;
                        n_idx          = '0;
                        n_valid        = '0;
                        n_pend.ack_seq = r_seq;
                        n_state        = S_EMIT;
                    end
                end else begin
                    case (r_type)
                        PKT_END: begin
                            n_open  = 1'b0;
                            n_state = S_EMIT;
                        end
                        PKT_ACK: begin
                            n_open      = 1'b0;
                            n_pend.kind = KIND_ERROR;
                            n_state     = S_EMIT;
                        end
                        PKT_DATA: begin
                            if (r_crc) begin
                                if (stale) begin
                                    n_pend.ack_seq = r_exp;
                                    n_state        = S_EMIT;
                                end else if (in_win) begin
                                    if (off == '0) begin
                                        n_valid[r_idx] = 1'b0;
                                        n_pend.kind    = KIND_DELIVER;
                                        n_pend.tag     = r_tag;
                                        n_pend.len     = r_len;
                                        n_pend.last    = 1'b0;
                                        n_exp          = r_exp + 32'd1;
                                        n_idx          = idx_inc;
                                        n_after        = more ? S_RD : S_ACK;
                                    end else begin
                                        mem_wr_en         = 1'b1;
                                        n_valid[slot_buf] = 1'b1;
                                        n_pend.ack_seq    = r_exp;
                                    end
                                    n_state = S_EMIT;
                                end
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (out_ready) begin
                    out_push = 1'b1;
                    n_state  = r_after;
                end
            end
            S_RD: begin
                mem_rd_en = 1'b1;
                n_state   = S_RDW;
            end
            S_RDW: begin
                n_valid[r_idx] = 1'b0;
                n_pend.kind    = KIND_DELIVER;
                n_pend.ack_seq = '0;
                n_pend.tag     = mem_rd_data.tag;
                n_pend.len     = mem_rd_data.len;
                n_pend.last    = 1'b0;
                n_exp          = r_exp + 32'd1;
                n_idx          = idx_inc;
                n_after        = more ? S_RD : S_ACK;
                n_state        = S_EMIT;
            end
            S_ACK: begin
                n_pend.kind    = KIND_ACK;
                n_pend.ack_seq = r_exp;
                n_pend.tag     = '0;
                n_pend.len     = '0;
                n_pend.last    = 1'b1;
                n_after        = S_IDLE;
                n_state        = S_EMIT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_after       <= S_IDLE;
            r_open        <= 1'b0;
            r_exp         <= '0;
            r_idx         <= '0;
            r_valid       <= '0;
            r_window_size <= WINDOW_RESET;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_open  <= n_open;
            r_exp   <= n_exp;
            r_idx   <= n_idx;
            r_valid <= n_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_window_size <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (in_accept) begin
            r_type <= i_pkt_type;
            r_seq  <= i_seq_num;
            r_crc  <= i_crc_ok;
            r_tag  <= i_payload_tag;
            r_len  <= sat_len;
        end
    end

    srr_slot_mem #(
        .DEPTH(WINDOW)
    ) u_slot_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (slot_buf),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (mem_rd_data)
    );

    srr_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_res   (r_pend),
        .o_ready (out_ready),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (out_res)
    );

    assign o_kind            = out_res.kind;
    assign o_ack_seq         = out_res.ack_seq;
    assign o_payload_tag_res = out_res.tag;
    assign o_payload_len_res = out_res.len;
    assign o_last            = out_res.last;

    `SRR_ASSERT_NXT(a_accept_to_eval, i_clk, i_rst_n, in_accept, r_state == S_EVAL)
    `SRR_ASSERT_IMP(a_drain_slot_valid, i_clk, i_rst_n, r_state == S_RDW, r_valid[r_idx])
    `SRR_ASSERT_NXT(a_start_clears, i_clk, i_rst_n, (r_state == S_EVAL) && !r_open && (r_type == PKT_START), r_open && (r_valid == '0) && (r_exp == '0))

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for the selective repeat receiver.
`timescale 1ns / 1ps

module testbench;
    import srr_pkg::*;

    localparam int unsigned   PERIOD       = 4;
    localparam int unsigned   WINDOW       = 32;
    localparam logic [10:0]   PAYLOAD_MAX  = 11'd1456;
    localparam int unsigned   SETTLE_TICKS = 16;
    localparam int unsigned   END_TICKS    = 120;
    localparam int unsigned   HOLD_TICKS   = 300;
    localparam int unsigned   QUIET_LIMIT  = 4000;

    typedef struct packed {
        t_pkt_type   ptype;
        logic [31:0] seq;
        logic        crc;
        logic [9:0]  tag;
        logic [10:0] len;
        logic        typed;
        t_kind       kind;
        logic [31:0] ack;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_pkt_type = PKT_START;
    logic [31:0] i_seq_num = '0;
    logic        i_crc_ok = 1'b0;
    logic [9:0]  i_payload_tag = '0;
    logic [10:0] i_payload_len = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_kind;
    logic [31:0] o_ack_seq;
    logic [9:0]  o_payload_tag_res;
    logic [10:0] o_payload_len_res;
    logic        o_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [5:0]  i_cfg_data = '0;

    // Shadow copy of the receiver state used to predict answers.
    logic [5:0]  window_reg = WINDOW_RESET;
    logic        rx_open = 1'b0;
    logic [31:0] rx_next_seq = '0;
    logic [WINDOW-1:0] held_valid = '0;
    logic [9:0]  held_tag [WINDOW];
    logic [10:0] held_len [WINDOW];

    t_result     pending_answers [$];
    t_row        plan [$];
    t_result     head;
    int unsigned caused;
    int unsigned answered_headers = 0;
    int unsigned mismatches = 0;
    logic        calm = 1'b0;
    logic        hold_req = 1'b0;

    selective_repeat_receiver DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_pkt_type        (i_pkt_type),
        .i_seq_num         (i_seq_num),
        .i_crc_ok          (i_crc_ok),
        .i_payload_tag     (i_payload_tag),
        .i_payload_len     (i_payload_len),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_kind            (o_kind),
        .o_ack_seq         (o_ack_seq),
        .o_payload_tag_res (o_payload_tag_res),
        .o_payload_len_res (o_payload_len_res),
        .o_last            (o_last),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    always #(PERIOD / 2) i_clk = ~i_clk;

    function automatic int unsigned live_window();
        if (window_reg == 6'd0) begin
            return 1;
        end
        if (window_reg > WINDOW) begin
            return WINDOW;
        end
        return window_reg;
    endfunction

    function automatic void note_answer(input t_kind kind, input logic [31:0] ack,
                                        input logic [9:0] tag, input logic [10:0] len);
        t_result r;
        r.kind    = kind;
        r.ack_seq = ack;
        r.tag     = tag;
        r.len     = len;
        r.last    = 1'b0;
        pending_answers = {pending_answers, r};
        caused++;
    endfunction

    function automatic void answer_header(input t_pkt_type ptype, input logic [31:0] seq,
                                          input logic crc, input logic [9:0] tag,
                                          input logic [10:0] len_in);
        logic [10:0] len;
        logic [31:0] gap;
        logic [31:0] e;
        int unsigned k;
        t_result     r;
        caused = 0;
        len = (len_in > PAYLOAD_MAX) ? PAYLOAD_MAX : len_in;
        if (!rx_open) begin
            if (ptype == PKT_START) begin
                rx_open     = 1'b1;
                rx_next_seq = '0;
                held_valid  = '0;
                note_answer(KIND_ACK, seq, '0, '0);
            end
        end else if (ptype == PKT_END) begin
            rx_open = 1'b0;
            note_answer(KIND_ACK, '0, '0, '0);
        end else if (ptype == PKT_ACK) begin
            rx_open = 1'b0;
            note_answer(KIND_ERROR, '0, '0, '0);
        end else if (ptype == PKT_DATA && crc) begin
            gap = seq - rx_next_seq;
            if (gap[31]) begin
                note_answer(KIND_ACK, rx_next_seq, '0, '0);
            end else if (gap < live_window()) begin
                if (gap == '0) begin
                    held_valid[rx_next_seq % WINDOW] = 1'b0;
                    note_answer(KIND_DELIVER, '0, tag, len);
                    e = rx_next_seq + 32'd1;
                    k = 1;
                    while (k < WINDOW && held_valid[e % WINDOW]) begin
                        note_answer(KIND_DELIVER, '0, held_tag[e % WINDOW], held_len[e % WINDOW]);
                        held_valid[e % WINDOW] = 1'b0;
                        e = e + 32'd1;
                        k++;
                    end
                    rx_next_seq = e;
                    note_answer(KIND_ACK, rx_next_seq, '0, '0);
                end else begin
                    held_valid[seq % WINDOW] = 1'b1;
                    held_tag[seq % WINDOW]   = tag;
                    held_len[seq % WINDOW]   = len;
                    note_answer(KIND_ACK, rx_next_seq, '0, '0);
                end
            end
        end
        if (caused != 0) begin
            r = pending_answers.pop_back();
            r.last = 1'b1;
            pending_answers = {pending_answers, r};
        end
    endfunction

    function automatic logic [9:0] rand_tag();
        return 10'($urandom_range(1023));
    endfunction

    function automatic logic [10:0] rand_len();
        return 11'($urandom_range(2047));
    endfunction

    task automatic send_header(input t_pkt_type ptype, input logic [31:0] seq, input logic crc,
                               input logic [9:0] tag, input logic [10:0] len);
        while (!calm && $urandom_range(99) < 19) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_pkt_type    <= ptype;
        i_seq_num     <= seq;
        i_crc_ok      <= crc;
        i_payload_tag <= tag;
        i_payload_len <= len;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        answer_header(ptype, seq, crc, tag, len);
        if (caused != 0) begin
            answered_headers++;
        end
    endtask

    task automatic send_data(input logic [31:0] seq);
        int unsigned r;
        logic [31:0] s;
        r = $urandom_range(99);
        s = seq;
        if (r < 5) begin
            s = seq - 32'($urandom_range(1, 40));
        end else if (r < 9) begin
            s = seq + 32'(live_window() + $urandom_range(0, 20));
        end
        send_header(PKT_DATA, s, !(r >= 14 && r < 20), rand_tag(), rand_len());
        if (r >= 9 && r < 14) begin
            send_header(PKT_DATA, s, 1'b1, rand_tag(), rand_len());
        end
    endtask

    task automatic random_phase(input int unsigned goal);
        int unsigned start_count;
        int unsigned pick;
        int unsigned n;
        int          k;
        int          j;
        int unsigned tmp;
        int unsigned order [WINDOW];
        logic [31:0] base;
        start_count = answered_headers;
        while (answered_headers - start_count < goal) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                send_header(t_pkt_type'($urandom_range(3)), $urandom(), 1'($urandom_range(1)),
                            rand_tag(), rand_len());
            end else if (!rx_open) begin
                send_header(PKT_START, $urandom(), 1'($urandom_range(1)), rand_tag(), rand_len());
            end else if (pick < 16) begin
                send_header(PKT_END, $urandom(), 1'($urandom_range(1)), rand_tag(), rand_len());
            end else if (pick < 18) begin
                send_header(PKT_ACK, $urandom(), 1'($urandom_range(1)), rand_tag(), rand_len());
            end else if (pick < 20) begin
                send_header(PKT_START, $urandom(), 1'($urandom_range(1)), rand_tag(), rand_len());
            end else begin
                // Send the packets ahead of the expected one out of order, then the gap filler.
                base = rx_next_seq;
                n = ($urandom_range(3) == 0) ? live_window() : $urandom_range(1, live_window());
                for (k = 0; k < int'(n) - 1; k++) begin
                    order[k] = k + 1;
                end
                for (k = int'(n) - 2; k > 0; k--) begin
                    j = $urandom_range(k);
                    tmp = order[k];
                    order[k] = order[j];
                    order[j] = tmp;
                end
                for (k = 0; k < int'(n) - 1; k++) begin
                    send_data(base + order[k]);
                end
                send_header(PKT_DATA, base, ($urandom_range(9) != 0), rand_tag(), rand_len());
            end
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [5:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        window_reg = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_row(input t_pkt_type ptype, input logic [31:0] seq, input logic crc,
                           input logic [9:0] tag, input logic [10:0] len,
                           input logic typed, input t_kind kind, input logic [31:0] ack);
        t_row row;
        row.ptype = ptype;
        row.seq   = seq;
        row.crc   = crc;
        row.tag   = tag;
        row.len   = len;
        row.typed = typed;
        row.kind  = kind;
        row.ack   = ack;
        plan = {plan, row};
    endtask

    function automatic void compare(input string field, input logic [31:0] want,
                                    input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: result with nothing expected, kind %0d ack_seq %0h",
                         $time, o_kind, o_ack_seq);
                mismatches++;
            end else begin
                head = pending_answers.pop_front();
                compare("kind", 32'(head.kind), 32'(o_kind));
                compare("ack_seq", head.ack_seq, o_ack_seq);
                compare("payload_tag_res", 32'(head.tag), 32'(o_payload_tag_res));
                compare("payload_len_res", 32'(head.len), 32'(o_payload_len_res));
                compare("last", 32'(head.last), 32'(o_last));
            end
        end
    end

    initial begin : sink
        int unsigned k;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                for (k = 0; k < HOLD_TICKS; k++) begin
                    @(posedge i_clk);
                end
                hold_req = 1'b0;
            end
            i_out_stall <= !calm && ($urandom_range(99) < 19);
        end
    end

    initial begin : watchdog
        int unsigned quiet_ticks;
        quiet_ticks = 0;
        while (quiet_ticks < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet_ticks = 0;
            end else begin
                quiet_ticks++;
            end
        end
        $display("** selective_repeat_receiver: FAILED **");
        $finish;
    end

    initial begin : stimulus
        t_row    row;
        t_result fixed;
        int      i;
        // The window stays at its reset value of 8 for the directed part.
        add_row(PKT_DATA,  32'd5,          1'b1, 10'd7,     11'd20,   1'b0, KIND_ACK, '0);
        add_row(PKT_END,   32'd0,          1'b1, 10'd0,     11'd0,    1'b0, KIND_ACK, '0);
        add_row(PKT_ACK,   32'd0,          1'b1, 10'd0,     11'd0,    1'b0, KIND_ACK, '0);
        add_row(PKT_START, 32'hFFFF_FFFF,  1'b0, 10'd0,     11'd0,    1'b1, KIND_ACK,
                32'hFFFF_FFFF);
        add_row(PKT_START, 32'd7,          1'b1, 10'd9,     11'd9,    1'b0, KIND_ACK, '0);
        add_row(PKT_DATA,  32'd0,          1'b1, 10'h3FF,   11'h7FF,  1'b0, KIND_ACK, '0);
        add_row(PKT_DATA,  32'd1,          1'b0, 10'd11,    11'd11,   1'b0, KIND_ACK, '0);
        add_row(PKT_DATA,  32'd3,          1'b1, 10'd3,     11'd0,    1'b1, KIND_ACK, 32'd1);
        add_row(PKT_DATA,  32'd3,          1'b1, 10'd4,     11'd1456, 1'b1, KIND_ACK, 32'd1);
        add_row(PKT_DATA,  32'd2,          1'b1, 10'h155,   11'd1457, 1'b0, KIND_ACK, '0);
        add_row(PKT_DATA,  32'd9,          1'b1, 10'd5,     11'd5,    1'b0, KIND_ACK, '0);
        add_row(PKT_DATA,  32'd8,          1'b1, 10'h2AA,   11'd1,    1'b0, KIND_ACK, '0);
        add_row(PKT_DATA,  32'd0,          1'b1, 10'd6,     11'd6,    1'b1, KIND_ACK, 32'd1);
        add_row(PKT_DATA,  32'h8000_0001,  1'b1, 10'd6,     11'd6,    1'b1, KIND_ACK, 32'd1);
        add_row(PKT_DATA,  32'h8000_0000,  1'b1, 10'd6,     11'd6,    1'b0, KIND_ACK, '0);
        add_row(PKT_DATA,  32'd1,          1'b1, 10'd1,     11'd1456, 1'b0, KIND_ACK, '0);
        add_row(PKT_END,   32'd77,         1'b1, 10'd0,     11'd0,    1'b1, KIND_ACK, 32'd0);
        add_row(PKT_START, 32'h1234_5678,  1'b1, 10'd0,     11'd0,    1'b1, KIND_ACK,
                32'h1234_5678);
        add_row(PKT_DATA,  32'd0,          1'b1, 10'd100,   11'd200,  1'b0, KIND_ACK, '0);
        add_row(PKT_ACK,   32'd1,          1'b1, 10'd0,     11'd0,    1'b1, KIND_ERROR, 32'd0);
        add_row(PKT_START, 32'd0,          1'b1, 10'd0,     11'd0,    1'b1, KIND_ACK, 32'd0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < plan.size(); i++) begin
            row = plan[i];
            send_header(row.ptype, row.seq, row.crc, row.tag, row.len);
            if (row.typed) begin
                repeat (caused) void'(pending_answers.pop_back());
                fixed.kind    = row.kind;
                fixed.ack_seq = row.ack;
                fixed.tag     = '0;
                fixed.len     = '0;
                fixed.last    = 1'b1;
                pending_answers = {pending_answers, fixed};
            end
        end

        settle();
        write_window(6'd0);
        hold_req = 1'b1;
        random_phase(10);

        settle();
        write_window(6'd63);
        calm = 1'b1;
        random_phase(15);
        calm = 1'b0;

        settle();
        write_window(6'd32);
        random_phase(15);

        settle();
        write_window(6'd1);
        random_phase(10);

        settle();
        write_window(6'($urandom_range(2, 31)));
        random_phase(10);

        settle();
        repeat (END_TICKS) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("** selective_repeat_receiver: PASSED **");
        end else begin
            $display("** selective_repeat_receiver: FAILED **");
        end
        $finish;
    end

endmodule
